// File: design/fpc_pkg.sv
// Package for the five-stage pipeline core: stage register types, opcodes and
// small helper functions. No dependencies.
package fpc_pkg;

  localparam int unsigned DefRegCount = 32;
  localparam int unsigned DefMemWords = 16;
  localparam int unsigned RegNumW     = 5;
  localparam int unsigned LuiShift    = 12;
  localparam logic [31:0] PcStep      = 32'd4;

  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_ADDI = 3'd1,
    FN_LW   = 3'd2,
    FN_SW   = 3'd3,
    FN_BEQ  = 3'd4,
    FN_BLT  = 3'd5,
    FN_LUI  = 3'd6
  } func_e;

  // Fetch/decode and decode/execute stage contents.
  typedef struct packed {
    logic               valid;
    logic [2:0]         func;
    logic [RegNumW-1:0] rd;
    logic [RegNumW-1:0] rs1;
    logic [RegNumW-1:0] rs2;
    logic [31:0]        imm;
    logic [31:0]        pc;
  } dec_stage_t;

  // Execute/memory stage contents; sdata is the forwarded store operand.
  typedef struct packed {
    logic               valid;
    logic               taken;
    logic [2:0]         func;
    logic [RegNumW-1:0] rd;
    logic [31:0]        imm;
    logic [31:0]        pc;
    logic [31:0]        val;
    logic [31:0]        sdata;
  } ex_stage_t;

  // Memory/write-back stage contents.
  typedef struct packed {
    logic               valid;
    logic [2:0]         func;
    logic [RegNumW-1:0] rd;
    logic [31:0]        val;
  } wb_stage_t;

  function automatic logic writes_reg(logic [2:0] f);
    logic w;
    case (func_e'(f))
      FN_ADD, FN_ADDI, FN_LW, FN_LUI: w = 1'b1;
      default:                        w = 1'b0;
    endcase
    return w;
  endfunction

  // Register number modulo n by restoring subtraction over the five bits.
  function automatic logic [RegNumW-1:0] reg_mod(logic [RegNumW-1:0] v, int unsigned n);
    int unsigned r;
    r = int'(v);
    for (int k = RegNumW - 1; k >= 0; k--) begin
      if (r >= (n << k)) begin
        r = r - (n << k);
      end
    end
    return RegNumW'(r);
  endfunction

endpackage

// File: design/fpc_if.sv
// Handshake interfaces for the instruction input and the per-tick result.
// Depends on nothing.
interface fpc_inst_if;
  logic               valid;
  logic               ready;
  logic               inst_valid;
  logic [2:0]         func;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [19:0] immediate;

  modport source (output valid, inst_valid, func, dest_reg, src1_reg, src2_reg, immediate,
                  input ready);
  modport sink   (input valid, inst_valid, func, dest_reg, src1_reg, src2_reg, immediate,
                  output ready);
endinterface

interface fpc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] fetch_pc;
  logic        wb_valid;
  logic [4:0]  wb_reg;
  logic [31:0] wb_value;
  logic        store_valid;
  logic [3:0]  store_index;
  logic [31:0] store_value;
  logic        branch_taken;
  logic        pipe_idle;

  modport source (output valid, fetch_pc, wb_valid, wb_reg, wb_value, store_valid,
                  store_index, store_value, branch_taken, pipe_idle, input ready);
  modport sink   (input valid, fetch_pc, wb_valid, wb_reg, wb_value, store_valid,
                  store_index, store_value, branch_taken, pipe_idle, output ready);
endinterface

// File: design/fpc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module fpc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/fpc_regfile.sv
// Register file with two read ports built from two RAM copies, plus a bypass
// of the write made in the cycle of the read. Depends on fpc_ram.
module fpc_regfile #(
  parameter int unsigned RegCount = 32,
  localparam int unsigned IdxW = (RegCount > 1) ? $clog2(RegCount) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [31:0]     wdata_i,
  input  logic [IdxW-1:0] raddr1_i,
  input  logic [IdxW-1:0] raddr2_i,
  output logic [31:0]     rdata1_o,
  output logic [31:0]     rdata2_o
);

  logic [31:0]     ram1, ram2;
  logic            byp_en_q;
  logic [IdxW-1:0] byp_addr_q, raddr1_q, raddr2_q;
  logic [31:0]     byp_data_q;

  fpc_ram #(.Width(32), .Depth(RegCount)) u_ram1 (
    .clk_i, .we_i, .waddr_i, .wdata_i, .raddr_i(raddr1_i), .rdata_o(ram1)
  );
  fpc_ram #(.Width(32), .Depth(RegCount)) u_ram2 (
    .clk_i, .we_i, .waddr_i, .wdata_i, .raddr_i(raddr2_i), .rdata_o(ram2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_en_q <= 1'b0;
    end else begin
      byp_en_q <= we_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_addr_q <= waddr_i;
    byp_data_q <= wdata_i;
    raddr1_q   <= raddr1_i;
    raddr2_q   <= raddr2_i;
  end

  // The RAM returns the old word when read and written in one cycle.
  assign rdata1_o = (byp_en_q && byp_addr_q == raddr1_q) ? byp_data_q : ram1;
  assign rdata2_o = (byp_en_q && byp_addr_q == raddr2_q) ? byp_data_q : ram2;

endmodule

// File: design/five_stage_pipeline_core.sv
// Top level of the five-stage pipeline core: stage registers, forwarding,
// data memory and result register. Depends on fpc_pkg, fpc_if, fpc_regfile, fpc_ram.
//
//   Port     Dir  Transfer carries
//   inst_i   in   one clock tick: the decoded instruction fetched at fetch_pc
//   res_o    out  the outcome of that tick: fetch_pc, write-back, store, flags
//
// Every input transfer advances the whole pipeline by one tick and yields one
// result transfer; with the result side ready a tick completes every cycle.
// After reset a clearing pass writes zero into every entry of the register file and
// data memory, during which inst_i.ready is low. A result waits in an output register;
// a new tick is taken in the same cycle as the waiting result is transferred.
// Operands are read ahead from synchronous RAMs, addressed by the next stage contents,
// and corrected by forwarding from MEM, WB and the bypass.
module five_stage_pipeline_core #(
  parameter int unsigned REG_COUNT = fpc_pkg::DefRegCount,
  parameter int unsigned MEM_WORDS = fpc_pkg::DefMemWords
) (
  input  logic clk_i,
  input  logic rst_ni,
  fpc_inst_if.sink  inst_i,
  fpc_res_if.source res_o
);

  localparam int unsigned RegIdxW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int unsigned MemIdxW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned ClrLen  = (REG_COUNT > MEM_WORDS) ? REG_COUNT : MEM_WORDS;
  localparam int unsigned ClrW    = $clog2(ClrLen + 1);
  localparam bit          MemPow2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);
  // Reciprocal for the word-index remainder when the depth is not a power of two.
  localparam int unsigned RecipSh = 30 + MemIdxW;
  localparam logic [63:0] Recip   = ((64'd1 << RecipSh) + 64'(MEM_WORDS) - 64'd1)
                                    / 64'(MEM_WORDS);

  // Word index of a byte address: (addr >> 2) modulo MEM_WORDS.
  function automatic logic [MemIdxW-1:0] mem_index(logic [31:0] addr);
    logic [29:0] w;
    logic [63:0] p;
    logic [29:0] q;
    logic [29:0] r;
    w = addr[31:2];
    p = 64'(w) * Recip;
    q = 30'(p >> RecipSh);
    r = w - 30'(q * 30'(MEM_WORDS));
    if (MemPow2) begin
      return w[MemIdxW-1:0];
    end
    return r[MemIdxW-1:0];
  endfunction

  function automatic logic [RegIdxW-1:0] ridx(logic [fpc_pkg::RegNumW-1:0] r);
    return r[RegIdxW-1:0];
  endfunction

  // Stage registers and program counter.
  fpc_pkg::dec_stage_t fd_q, fd_d, de_q, de_d;
  fpc_pkg::ex_stage_t  em_q, em_d;
  fpc_pkg::wb_stage_t  mw_q, mw_d;
  logic [31:0]         pc_q, pc_d;

  // Clearing pass after reset.
  logic            clr_q;
  logic [ClrW-1:0] clr_cnt_q;

  // Result register.
  logic        res_valid_q;
  logic [31:0] res_pc_q, res_wb_value_q, res_st_value_q;
  logic        res_wb_valid_q, res_st_valid_q, res_taken_q, res_idle_q;
  logic [4:0]  res_wb_reg_q;
  logic [3:0]  res_st_index_q;

  logic tick;
  assign inst_i.ready = !clr_q && (!res_valid_q || res_o.ready);
  assign tick         = inst_i.valid && inst_i.ready;

  // Register file and data memory ports.
  logic               rf_we;
  logic [RegIdxW-1:0] rf_waddr;
  logic [31:0]        rf_wdata, rf_rd1, rf_rd2;

  logic               dm_we;
  logic [MemIdxW-1:0] dm_waddr, dm_raddr, dm_raddr_q, dm_byp_addr_q;
  logic [31:0]        dm_wdata, dm_ram, dm_byp_data_q, load_data;
  logic               dm_byp_en_q;

  fpc_regfile #(.RegCount(REG_COUNT)) u_regfile (
    .clk_i, .rst_ni,
    .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr1_i(ridx(de_d.rs1)), .raddr2_i(ridx(de_d.rs2)),
    .rdata1_o(rf_rd1), .rdata2_o(rf_rd2)
  );

  fpc_ram #(.Width(32), .Depth(MEM_WORDS)) u_dmem (
    .clk_i, .we_i(dm_we), .waddr_i(dm_waddr), .wdata_i(dm_wdata),
    .raddr_i(dm_raddr), .rdata_o(dm_ram)
  );

  assign load_data = (dm_byp_en_q && dm_byp_addr_q == dm_raddr_q) ? dm_byp_data_q : dm_ram;

  // Tick logic: WB, MEM, EX, ID and IF in the order of the architectural step.
  logic               wb_en, st_en, taken;
  logic [31:0]        target, opa, opb;
  logic [MemIdxW-1:0] em_idx;
  fpc_pkg::wb_stage_t nmw;
  fpc_pkg::ex_stage_t nem;
  fpc_pkg::dec_stage_t nde, nfd;

  assign em_idx = mem_index(em_q.val);

  always_comb begin
    wb_en = mw_q.valid && fpc_pkg::writes_reg(mw_q.func) && (mw_q.rd != '0);

    // MEM: load, store or branch resolution.
    nmw    = '0;
    st_en  = 1'b0;
    taken  = 1'b0;
    target = em_q.pc + em_q.imm;
    if (em_q.valid) begin
      nmw.valid = 1'b1;
      nmw.func  = em_q.func;
      nmw.rd    = em_q.rd;
      nmw.val   = em_q.val;
      case (fpc_pkg::func_e'(em_q.func))
        fpc_pkg::FN_LW:  nmw.val = load_data;
        fpc_pkg::FN_SW:  st_en = 1'b1;
        fpc_pkg::FN_BEQ,
        fpc_pkg::FN_BLT: taken = em_q.taken;
        default:         ;
      endcase
    end

    // EX operands: zero for register 0, else MEM result first, then this tick's write-back, then the file.
    if (de_q.rs1 == '0) begin
      opa = '0;
    end else if (nmw.valid && fpc_pkg::writes_reg(nmw.func) && nmw.rd == de_q.rs1) begin
      opa = nmw.val;
    end else if (wb_en && mw_q.rd == de_q.rs1) begin
      opa = mw_q.val;
    end else begin
      opa = rf_rd1;
    end
    if (de_q.rs2 == '0) begin
      opb = '0;
    end else if (nmw.valid && fpc_pkg::writes_reg(nmw.func) && nmw.rd == de_q.rs2) begin
      opb = nmw.val;
    end else if (wb_en && mw_q.rd == de_q.rs2) begin
      opb = mw_q.val;
    end else begin
      opb = rf_rd2;
    end

    // EX: the store operand read now equals the file seen by MEM next tick.
    nem = '0;
    if (de_q.valid && !taken) begin
      nem.valid = 1'b1;
      nem.func  = de_q.func;
      nem.rd    = de_q.rd;
      nem.imm   = de_q.imm;
      nem.pc    = de_q.pc;
      nem.sdata = opb;
      case (fpc_pkg::func_e'(de_q.func))
        fpc_pkg::FN_ADD:  nem.val = opa + opb;
        fpc_pkg::FN_ADDI,
        fpc_pkg::FN_LW,
        fpc_pkg::FN_SW:   nem.val = opa + de_q.imm;
        fpc_pkg::FN_BEQ:  nem.taken = (opa == opb);
        fpc_pkg::FN_BLT:  nem.taken = ($signed(opa) < $signed(opb));
        fpc_pkg::FN_LUI:  nem.val = de_q.imm << fpc_pkg::LuiShift;
        default:          ;
      endcase
    end

    // ID.
    nde = (fd_q.valid && !taken) ? fd_q : '0;

    // IF: a taken branch discards this tick's fetch.
    nfd  = '0;
    pc_d = pc_q;
    if (taken) begin
      pc_d = target;
    end else if (inst_i.inst_valid) begin
      nfd.valid = 1'b1;
      nfd.func  = inst_i.func;
      nfd.rd    = fpc_pkg::reg_mod(inst_i.dest_reg, REG_COUNT);
      nfd.rs1   = fpc_pkg::reg_mod(inst_i.src1_reg, REG_COUNT);
      nfd.rs2   = fpc_pkg::reg_mod(inst_i.src2_reg, REG_COUNT);
      nfd.imm   = {{12{inst_i.immediate[19]}}, inst_i.immediate};
      nfd.pc    = pc_q;
      pc_d      = pc_q + fpc_pkg::PcStep;
    end

    if (!tick) begin
      pc_d = pc_q;
    end
    fd_d = tick ? nfd : fd_q;
    de_d = tick ? nde : de_q;
    em_d = tick ? nem : em_q;
    mw_d = tick ? nmw : mw_q;
  end

  // Memory write and read ports, including the clearing pass.
  always_comb begin
    if (clr_q) begin
      rf_we    = (clr_cnt_q < ClrW'(REG_COUNT));
      rf_waddr = clr_cnt_q[RegIdxW-1:0];
      rf_wdata = '0;
      dm_we    = (clr_cnt_q < ClrW'(MEM_WORDS));
      dm_waddr = clr_cnt_q[MemIdxW-1:0];
      dm_wdata = '0;
    end else begin
      rf_we    = tick && wb_en;
      rf_waddr = ridx(mw_q.rd);
      rf_wdata = mw_q.val;
      dm_we    = tick && st_en;
      dm_waddr = em_idx;
      dm_wdata = em_q.sdata;
    end
    dm_raddr = mem_index(em_d.val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_q        <= '0;
      de_q        <= '0;
      em_q        <= '0;
      mw_q        <= '0;
      pc_q        <= '0;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      dm_byp_en_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      fd_q        <= fd_d;
      de_q        <= de_d;
      em_q        <= em_d;
      mw_q        <= mw_d;
      pc_q        <= pc_d;
      dm_byp_en_q <= dm_we;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == ClrW'(ClrLen - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (tick) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  logic [31:0] st_idx_ext;
  assign st_idx_ext = 32'(em_idx);

  always_ff @(posedge clk_i) begin
    dm_raddr_q    <= dm_raddr;
    dm_byp_addr_q <= dm_waddr;
    dm_byp_data_q <= dm_wdata;
    if (tick) begin
      res_pc_q       <= pc_d;
      res_wb_valid_q <= wb_en;
      res_wb_reg_q   <= wb_en ? mw_q.rd : '0;
      res_wb_value_q <= wb_en ? mw_q.val : '0;
      res_st_valid_q <= st_en;
      res_st_index_q <= st_en ? st_idx_ext[3:0] : '0;
      res_st_value_q <= st_en ? em_q.sdata : '0;
      res_taken_q    <= taken;
      res_idle_q     <= !(nfd.valid || nde.valid || nem.valid || nmw.valid);
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.fetch_pc     = res_pc_q;
  assign res_o.wb_valid     = res_wb_valid_q;
  assign res_o.wb_reg       = res_wb_reg_q;
  assign res_o.wb_value     = res_wb_value_q;
  assign res_o.store_valid  = res_st_valid_q;
  assign res_o.store_index  = res_st_index_q;
  assign res_o.store_value  = res_st_value_q;
  assign res_o.branch_taken = res_taken_q;
  assign res_o.pipe_idle    = res_idle_q;

endmodule
